>>> src/qrpm_pkg.sv
// Shared types, constants and helper functions for the quad rate PID motor mixer.
// Used by quad_rate_pid_motor_mixer, qrpm_mix and qrpm_check; depends on nothing else.
package qrpm_pkg;

  localparam int IN_W      = 168;
  localparam int OUT_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W    = 16;
  localparam int MOTOR_W   = 16;

  localparam int ERR_W  = 18;
  localparam int EI_W   = 21;
  localparam int YN_W   = 15;
  localparam int PE_W   = 35;
  localparam int PI_W   = 38;
  localparam int PYR_W  = 33;
  localparam int PYI_W  = 41;
  localparam int ACC_W  = 44;
  localparam int FRAC_W = 16;
  localparam int MIX_W  = ACC_W - FRAC_W;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 16'd9175;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST        = 16'd2949;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST        = 16'd262;
  localparam logic [GAIN_W-1:0]  GAIN_YAW_RATE_RST = 16'd5898;
  localparam logic [GAIN_W-1:0]  GAIN_YAW_INT_RST  = 16'd197;
  localparam logic [MOTOR_W-1:0] MOTOR_FLOOR_RST   = 16'd0;
  localparam logic [MOTOR_W-1:0] MOTOR_CEIL_RST    = 16'd65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P            = 3'd0,
    CFG_GAIN_I            = 3'd1,
    CFG_GAIN_D            = 3'd2,
    CFG_GAIN_YAW_RATE     = 3'd3,
    CFG_GAIN_YAW_INTEGRAL = 3'd4,
    CFG_MOTOR_FLOOR       = 3'd5,
    CFG_MOTOR_CEILING     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PE_W-1:0]  roll_p;
    logic signed [PI_W-1:0]  roll_i;
    logic signed [PE_W-1:0]  roll_d;
    logic signed [PE_W-1:0]  pitch_p;
    logic signed [PI_W-1:0]  pitch_i;
    logic signed [PE_W-1:0]  pitch_d;
    logic signed [PYR_W-1:0] yaw_r;
    logic signed [PYI_W-1:0] yaw_i;
    logic signed [YN_W-1:0]  yaw_neg;
    logic [MOTOR_W-1:0]      throttle;
  } qrpm_prod_t;

  // Divides a Q.16 accumulator by 65536, rounding toward zero.
  function automatic logic signed [MIX_W-1:0] trunc_q16(input logic signed [ACC_W-1:0] x);
    logic signed [MIX_W-1:0] q;
    q = x[ACC_W-1:FRAC_W];
    if (x[ACC_W-1] && (x[FRAC_W-1:0] != '0)) begin
      q = q + MIX_W'(1);
    end
    return q;
  endfunction

  // Raises to the floor first, then lowers to the ceiling, so the ceiling wins.
  function automatic logic [MOTOR_W-1:0] clamp_motor(input logic signed [MIX_W-1:0] v,
                                                     input logic [MOTOR_W-1:0] lo,
                                                     input logic [MOTOR_W-1:0] hi);
    logic signed [MIX_W-1:0] x;
    x = v;
    if (x < MIX_W'($signed({1'b0, lo}))) begin
      x = MIX_W'($signed({1'b0, lo}));
    end
    if (x > MIX_W'($signed({1'b0, hi}))) begin
      x = MIX_W'($signed({1'b0, hi}));
    end
    return x[MOTOR_W-1:0];
  endfunction

endpackage

>>> src/qrpm_mix.sv
// Sums the registered PID products, truncates them and forms and clamps the four X-frame motor values.
// Depends on qrpm_pkg for the product struct and the truncation and clamp functions.
module qrpm_mix (
  input  qrpm_pkg::qrpm_prod_t             prod,
  input  logic [qrpm_pkg::MOTOR_W-1:0]     motor_floor,
  input  logic [qrpm_pkg::MOTOR_W-1:0]     motor_ceiling,
  output logic [qrpm_pkg::OUT_W-1:0]       motors
);
  import qrpm_pkg::*;

  logic signed [ACC_W-1:0] roll_acc;
  logic signed [ACC_W-1:0] pitch_acc;
  logic signed [ACC_W-1:0] yaw_acc;
  logic signed [MIX_W-1:0] roll;
  logic signed [MIX_W-1:0] pitch;
  logic signed [MIX_W-1:0] yaw;
  logic signed [MIX_W-1:0] thr;
  logic signed [MIX_W-1:0] front_a;
  logic signed [MIX_W-1:0] front_b;
  logic signed [MIX_W-1:0] rear_a;
  logic signed [MIX_W-1:0] rear_b;

  always_comb begin
    roll_acc  = ACC_W'($signed(prod.roll_p)) + ACC_W'($signed(prod.roll_i))
              + ACC_W'($signed(prod.roll_d));
    pitch_acc = ACC_W'($signed(prod.pitch_p)) + ACC_W'($signed(prod.pitch_i))
              + ACC_W'($signed(prod.pitch_d));
    yaw_acc   = ACC_W'($signed({prod.yaw_neg, 16'h0000})) + ACC_W'($signed(prod.yaw_r))
              + ACC_W'($signed(prod.yaw_i));
    roll  = trunc_q16(roll_acc);
    pitch = trunc_q16(pitch_acc);
    yaw   = trunc_q16(yaw_acc);
    thr   = MIX_W'($signed({1'b0, prod.throttle}));
    front_a = thr - roll + pitch + yaw;
    front_b = thr - roll - pitch - yaw;
    rear_a  = thr + roll + pitch - yaw;
    rear_b  = thr + roll - pitch + yaw;
    motors = {clamp_motor(rear_b, motor_floor, motor_ceiling),
              clamp_motor(rear_a, motor_floor, motor_ceiling),
              clamp_motor(front_b, motor_floor, motor_ceiling),
              clamp_motor(front_a, motor_floor, motor_ceiling)};
  end

endmodule

>>> src/quad_rate_pid_motor_mixer.sv
// Rate PID for roll, pitch and yaw with an X-frame mixer and motor clamping.
// Depends on qrpm_pkg and instantiates qrpm_mix.
//
// Usage: each request on the s_ channel is one control tick carrying stick setpoints,
// gyro rates and integrals, yaw stick and throttle. Each tick yields exactly one request
// on the m_ channel with four clamped motor commands.
// The work runs in three register stages: the input stage forms the errors and updates
// the stored previous errors, the second stage holds the eight gain products, and the
// output register holds the mixed and clamped motor values.
// An accepted tick passes through the input stage, the product stage and the output register
// to m_tvalid; throughput is one tick per cycle while m_tready is high.
// When m_tready is low the output register holds its request and the earlier stages
// fill up; s_tready drops only once all three stages are occupied.
// The gain and limit registers are written over the cfg_ channel, which is always ready;
// they should be changed only while no tick is in flight. Index 7 is ignored.
// Reset empties the pipeline, clears the previous errors and loads the default gains.
module quad_rate_pid_motor_mixer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // roll_setpoint, pitch_setpoint, roll_rate, roll_integral, pitch_rate,
  // pitch_integral, yaw_rate, yaw_integral, yaw_stick, throttle
  input  logic [qrpm_pkg::IN_W-1:0]        s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b
  output logic [qrpm_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qrpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qrpm_pkg::GAIN_W-1:0]      cfg_data
);
  import qrpm_pkg::*;

  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [GAIN_W-1:0]  gain_yaw_rate;
  logic [GAIN_W-1:0]  gain_yaw_integral;
  logic [MOTOR_W-1:0] motor_floor;
  logic [MOTOR_W-1:0] motor_ceiling;

  logic signed [ERR_W-1:0] prev_roll_err;
  logic signed [ERR_W-1:0] prev_pitch_err;

  logic [7:0]         in_roll_sp;
  logic [7:0]         in_pitch_sp;
  logic signed [15:0] in_roll_rate;
  logic signed [23:0] in_roll_int;
  logic signed [15:0] in_pitch_rate;
  logic signed [23:0] in_pitch_int;
  logic signed [15:0] in_yaw_rate;
  logic signed [23:0] in_yaw_int;
  logic signed [15:0] in_yaw_stick;
  logic [15:0]        in_throttle;

  logic signed [ERR_W-1:0] roll_e_next;
  logic signed [EI_W-1:0]  roll_ei_next;
  logic signed [ERR_W-1:0] roll_ed_next;
  logic signed [ERR_W-1:0] pitch_e_next;
  logic signed [EI_W-1:0]  pitch_ei_next;
  logic signed [ERR_W-1:0] pitch_ed_next;
  logic signed [YN_W-1:0]  yaw_neg_next;

  logic                    s1_valid;
  logic signed [ERR_W-1:0] s1_roll_e;
  logic signed [EI_W-1:0]  s1_roll_ei;
  logic signed [ERR_W-1:0] s1_roll_ed;
  logic signed [ERR_W-1:0] s1_pitch_e;
  logic signed [EI_W-1:0]  s1_pitch_ei;
  logic signed [ERR_W-1:0] s1_pitch_ed;
  logic signed [15:0]      s1_yaw_rate;
  logic signed [23:0]      s1_yaw_int;
  logic signed [YN_W-1:0]  s1_yaw_neg;
  logic [15:0]             s1_throttle;

  logic       s2_valid;
  qrpm_prod_t s2_prod;
  qrpm_prod_t prod_next;

  logic [OUT_W-1:0] motors_next;
  logic             s1_ready;
  logic             s2_ready;
  logic             s_accept;

  function automatic logic signed [19:0] div16_tz(input logic signed [23:0] x);
    logic signed [23:0] q;
    q = x >>> 4;
    if (x[23] && (x[3:0] != 4'h0)) begin
      q = q + 24'sd1;
    end
    return q[19:0];
  endfunction

  function automatic logic signed [15:0] div4_tz(input logic signed [15:0] x);
    logic signed [15:0] q;
    q = x >>> 2;
    if (x[15] && (x[1:0] != 2'b00)) begin
      q = q + 16'sd1;
    end
    return q;
  endfunction

  assign in_roll_sp    = s_tdata[7:0];
  assign in_pitch_sp   = s_tdata[15:8];
  assign in_roll_rate  = s_tdata[31:16];
  assign in_roll_int   = s_tdata[55:32];
  assign in_pitch_rate = s_tdata[71:56];
  assign in_pitch_int  = s_tdata[95:72];
  assign in_yaw_rate   = s_tdata[111:96];
  assign in_yaw_int    = s_tdata[135:112];
  assign in_yaw_stick  = s_tdata[151:136];
  assign in_throttle   = s_tdata[167:152];

  assign s2_ready  = !m_tvalid || m_tready;
  assign s1_ready  = !s2_valid || s2_ready;
  assign s_tready  = !s1_valid || s1_ready;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    roll_e_next   = ERR_W'(in_roll_rate) + ERR_W'($signed({1'b0, in_roll_sp}));
    roll_ei_next  = EI_W'(div16_tz(in_roll_int)) + EI_W'($signed({1'b0, in_roll_sp}));
    roll_ed_next  = roll_e_next - prev_roll_err;
    pitch_e_next  = ERR_W'(in_pitch_rate) + ERR_W'($signed({1'b0, in_pitch_sp}));
    pitch_ei_next = EI_W'(div16_tz(in_pitch_int)) + EI_W'($signed({1'b0, in_pitch_sp}));
    pitch_ed_next = pitch_e_next - prev_pitch_err;
    yaw_neg_next  = YN_W'(-div4_tz(in_yaw_stick));
  end

  always_comb begin
    prod_next.roll_p   = $signed({1'b0, gain_p}) * s1_roll_e;
    prod_next.roll_i   = $signed({1'b0, gain_i}) * s1_roll_ei;
    prod_next.roll_d   = $signed({1'b0, gain_d}) * s1_roll_ed;
    prod_next.pitch_p  = $signed({1'b0, gain_p}) * s1_pitch_e;
    prod_next.pitch_i  = $signed({1'b0, gain_i}) * s1_pitch_ei;
    prod_next.pitch_d  = $signed({1'b0, gain_d}) * s1_pitch_ed;
    prod_next.yaw_r    = $signed({1'b0, gain_yaw_rate}) * s1_yaw_rate;
    prod_next.yaw_i    = $signed({1'b0, gain_yaw_integral}) * s1_yaw_int;
    prod_next.yaw_neg  = s1_yaw_neg;
    prod_next.throttle = s1_throttle;
  end

  qrpm_mix u_mix (
    .prod          (s2_prod),
    .motor_floor   (motor_floor),
    .motor_ceiling (motor_ceiling),
    .motors        (motors_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p            <= GAIN_P_RST;
      gain_i            <= GAIN_I_RST;
      gain_d            <= GAIN_D_RST;
      gain_yaw_rate     <= GAIN_YAW_RATE_RST;
      gain_yaw_integral <= GAIN_YAW_INT_RST;
      motor_floor       <= MOTOR_FLOOR_RST;
      motor_ceiling     <= MOTOR_CEIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAIN_P:            gain_p            <= cfg_data;
        CFG_GAIN_I:            gain_i            <= cfg_data;
        CFG_GAIN_D:            gain_d            <= cfg_data;
        CFG_GAIN_YAW_RATE:     gain_yaw_rate     <= cfg_data;
        CFG_GAIN_YAW_INTEGRAL: gain_yaw_integral <= cfg_data;
        CFG_MOTOR_FLOOR:       motor_floor       <= cfg_data;
        CFG_MOTOR_CEILING:     motor_ceiling     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
      prev_roll_err  <= '0;
      prev_pitch_err <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_ready) begin
        s2_valid <= s1_valid;
      end
      if (s2_ready) begin
        m_tvalid <= s2_valid;
      end
      if (s_accept) begin
        prev_roll_err  <= roll_e_next;
        prev_pitch_err <= pitch_e_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_roll_e   <= roll_e_next;
      s1_roll_ei  <= roll_ei_next;
      s1_roll_ed  <= roll_ed_next;
      s1_pitch_e  <= pitch_e_next;
      s1_pitch_ei <= pitch_ei_next;
      s1_pitch_ed <= pitch_ed_next;
      s1_yaw_rate <= in_yaw_rate;
      s1_yaw_int  <= in_yaw_int;
      s1_yaw_neg  <= yaw_neg_next;
      s1_throttle <= in_throttle;
    end
    if (s1_valid && s1_ready) begin
      s2_prod <= prod_next;
    end
    if (s2_valid && s2_ready) begin
      m_tdata <= motors_next;
    end
  end

endmodule

>>> src/qrpm_check.sv
// Port-level checks for quad_rate_pid_motor_mixer, attached by the bind at the end.
// Depends only on qrpm_pkg for the output width.
module qrpm_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [qrpm_pkg::OUT_W-1:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output request changed.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("Input stalled while the output is being drained.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("Accepted request did not reach the output in three cycles.");

endmodule

bind quad_rate_pid_motor_mixer qrpm_check u_qrpm_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
